@@ design/ptpd_pkg.sv @@
// Shared types, constants and helper functions for the pulse train packet detector.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ptpd_pkg;

  // Field widths fixed by the item format.
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 20;
  localparam int GLITCH_W = 10;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  // Default depth of the sample index space.
  localparam int unsigned MAX_SAMPLES_DEF = 1048576;

  // Saturation value of the run and packet counters.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_HOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_EXIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PKT    = 3'd4;

  // Configuration reset values.
  localparam logic [SAMPLE_W-1:0] HIGH_HOLD_RST  = 16'd1000;
  localparam logic [SAMPLE_W-1:0] LOW_EXIT_RST   = 16'd2000;
  localparam logic [GLITCH_W-1:0] GLITCH_LEN_RST = 10'd8;
  localparam logic [CNT_W-1:0]    EMPTY_LEN_RST  = 20'd4000;
  localparam logic [CNT_W-1:0]    MIN_PKT_RST    = 20'd16000;

  // Signal level codes.
  typedef enum logic [1:0] {
    LVL_IDLE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_HIGH = 2'd2
  } level_t;

  // Current configuration, as seen by the detector core.
  typedef struct packed {
    logic [SAMPLE_W-1:0] high_hold_threshold;
    logic [SAMPLE_W-1:0] low_exit_threshold;
    logic [GLITCH_W-1:0] glitch_length;
    logic [CNT_W-1:0]    empty_length;
    logic [CNT_W-1:0]    min_packet_length;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic             packet_found;
    logic [CNT_W-1:0] packet_start;
    logic [1:0]       level;
  } result_t;

  // Increment that stops at cap.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (v >= cap) begin
      r = cap;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

endpackage

@@ design/ptpd_cfg.sv @@
// Configuration register file of the pulse train packet detector.
// Depends on ptpd_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module ptpd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptpd_pkg::CFG_W-1:0]     cfg_wdata,
  output ptpd_pkg::cfg_t                cfg
);
  import ptpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index beyond the list leaves everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_HIGH_HOLD:  cfg_nxt.high_hold_threshold = cfg_wdata[SAMPLE_W-1:0];
        REG_LOW_EXIT:   cfg_nxt.low_exit_threshold  = cfg_wdata[SAMPLE_W-1:0];
        REG_GLITCH_LEN: cfg_nxt.glitch_length       = cfg_wdata[GLITCH_W-1:0];
        REG_EMPTY_LEN:  cfg_nxt.empty_length        = cfg_wdata[CNT_W-1:0];
        REG_MIN_PKT:    cfg_nxt.min_packet_length   = cfg_wdata[CNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register storage with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_hold_threshold <= HIGH_HOLD_RST;
      cfg_r.low_exit_threshold  <= LOW_EXIT_RST;
      cfg_r.glitch_length       <= GLITCH_LEN_RST;
      cfg_r.empty_length        <= EMPTY_LEN_RST;
      cfg_r.min_packet_length   <= MIN_PKT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/ptpd_core.sv @@
// Level tracker and packet state of the pulse train packet detector.
// Depends on ptpd_pkg for the level codes, the config and result types and sat_inc.
`timescale 1ns / 1ps

module ptpd_core #(
  parameter int unsigned MAX_SAMPLES = ptpd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [ptpd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          last_sample,
  input  ptpd_pkg::cfg_t                cfg,
  output ptpd_pkg::result_t             result
);
  import ptpd_pkg::*;

  // Highest sample index: the smaller of MAX_SAMPLES-1 and the counter limit.
  localparam int unsigned IDX_CAP_INT =
    (MAX_SAMPLES - 1 > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : MAX_SAMPLES - 1;
  localparam logic [CNT_W-1:0] IDX_CAP = CNT_W'(IDX_CAP_INT);

  level_t           level_r,      level_nxt;
  logic [CNT_W-1:0] run_length_r, run_length_nxt;
  logic [CNT_W-1:0] wrong_run_r,  wrong_run_nxt;
  logic [CNT_W-1:0] pkt_count_r,  pkt_count_nxt;
  logic [CNT_W-1:0] start_idx_r,  start_idx_nxt;
  logic [CNT_W-1:0] sample_idx_r, sample_idx_nxt;

  logic [CNT_W-1:0] run_inc;
  logic [CNT_W-1:0] wrong_inc;
  logic [CNT_W-1:0] pkt_inc;
  logic [CNT_W-1:0] glitch_ext;
  logic             found;
  logic [CNT_W-1:0] found_start;

  // Level update for one sample, then the end-of-buffer clear.
  always_comb begin
    run_inc    = sat_inc(run_length_r, CNT_MAX);
    wrong_inc  = sat_inc(wrong_run_r, CNT_MAX);
    pkt_inc    = sat_inc(pkt_count_r, CNT_MAX);
    glitch_ext = {{(CNT_W - GLITCH_W){1'b0}}, cfg.glitch_length};

    level_nxt      = level_r;
    run_length_nxt = run_length_r;
    wrong_run_nxt  = wrong_run_r;
    pkt_count_nxt  = pkt_inc;
    start_idx_nxt  = start_idx_r;
    found          = 1'b0;
    found_start    = '0;

    if (level_r == LVL_HIGH) begin
      if (sample > cfg.high_hold_threshold) begin
        wrong_run_nxt = '0;
        // First confirmed high sample marks where the packet began.
        if (start_idx_r == '0) begin
          start_idx_nxt = (sample_idx_r >= run_length_r) ?
                          (sample_idx_r - run_length_r) : '0;
        end
        run_length_nxt = run_inc;
      end else begin
        wrong_run_nxt = wrong_inc;
        if (wrong_inc > glitch_ext) begin
          run_length_nxt = wrong_inc;
          wrong_run_nxt  = '0;
          level_nxt      = LVL_LOW;
        end
      end
    end else begin
      if (!(sample > cfg.low_exit_threshold)) begin
        // A long enough quiet run closes the packet.
        if (run_length_r > cfg.empty_length) begin
          if ((pkt_inc >= cfg.min_packet_length) && (start_idx_r != '0)) begin
            found       = 1'b1;
            found_start = start_idx_r;
          end
          pkt_count_nxt = '0;
          start_idx_nxt = '0;
          level_nxt     = LVL_IDLE;
        end
        run_length_nxt = run_inc;
        wrong_run_nxt  = '0;
      end else begin
        wrong_run_nxt = wrong_inc;
        if (wrong_inc > glitch_ext) begin
          run_length_nxt = wrong_inc;
          wrong_run_nxt  = '0;
          level_nxt      = LVL_HIGH;
        end
      end
    end

    sample_idx_nxt = sat_inc(sample_idx_r, IDX_CAP);

    result.packet_found = found;
    result.packet_start = found_start;
    result.level        = level_nxt;

    // The last item of a buffer returns all state to its reset values.
    if (last_sample) begin
      level_nxt      = LVL_IDLE;
      run_length_nxt = '0;
      wrong_run_nxt  = '0;
      pkt_count_nxt  = '0;
      start_idx_nxt  = '0;
      sample_idx_nxt = '0;
    end
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= LVL_IDLE;
      run_length_r <= '0;
      wrong_run_r  <= '0;
      pkt_count_r  <= '0;
      start_idx_r  <= '0;
      sample_idx_r <= '0;
    end else if (accept) begin
      level_r      <= level_nxt;
      run_length_r <= run_length_nxt;
      wrong_run_r  <= wrong_run_nxt;
      pkt_count_r  <= pkt_count_nxt;
      start_idx_r  <= start_idx_nxt;
      sample_idx_r <= sample_idx_nxt;
    end
  end

endmodule

@@ design/ptpd_out.sv @@
// Two-entry result stage: an output register and a skid register behind it.
// Depends on ptpd_pkg for the result type.
`timescale 1ns / 1ps

module ptpd_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ptpd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ptpd_pkg::result_t out_data
);
  import ptpd_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_data_r,  main_data_nxt;
  result_t skid_data_r,  skid_data_nxt;
  logic    take;
  logic    main_free;

  // Fill the output register first, park an item in the skid when it is held.
  always_comb begin
    take           = main_valid_r && !out_stall;
    main_free      = !main_valid_r || take;
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  // Valid flags are reset; payload registers load freely.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

@@ design/pulse_train_packet_detector.sv @@
// Top level of the pulse train packet detector.
// Depends on ptpd_pkg, ptpd_cfg, ptpd_core and ptpd_out.
`timescale 1ns / 1ps

// The detector takes one sample item per clock cycle while in_stall is low and
// returns exactly one result item for each, through the output register or, when
// that is held, the skid register first. The level and packet state update is a
// single pass of compares and saturating counters between the state registers
// and the output register, so one item per cycle is sustained while out_stall is
// low. Results leave through an output register backed by a skid register;
// in_stall rises only when both hold an item that out_stall keeps waiting.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata and takes
// effect on the next item; write it only while no item is in flight.

module pulse_train_packet_detector #(
  parameter int unsigned MAX_SAMPLES = ptpd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptpd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptpd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           in_last_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_packet_found,
  output logic [ptpd_pkg::CNT_W-1:0]     out_packet_start,
  output logic [1:0]                     out_level
);
  import ptpd_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_data;
  logic    accept;
  logic    full;

  // An item is taken whenever the skid register is free.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  ptpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ptpd_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .sample      (in_sample),
    .last_sample (in_last_sample),
    .cfg         (cfg),
    .result      (result)
  );

  ptpd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_packet_found = out_data.packet_found;
  assign out_packet_start = out_data.packet_start;
  assign out_level        = out_data.level;

endmodule

@@ design/ptpd_checker.sv @@
// Port-level checks for the pulse train packet detector, bound to the top level.
// Depends on ptpd_pkg for widths and level codes.
`timescale 1ns / 1ps

module ptpd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_packet_found,
  input logic [ptpd_pkg::CNT_W-1:0]    out_packet_start,
  input logic [1:0]                    out_level
);
  import ptpd_pkg::*;

  // The input side only backs up when a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result item waiting");

  // A held result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_packet_found) &&
                                  $stable(out_packet_start) && $stable(out_level)))
    else $error("stalled result item changed");

  // A reported packet always returns the detector to idle.
  a_found_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_found) |-> (out_level == LVL_IDLE))
    else $error("packet reported without return to idle");

  // No start index is shown unless a packet is reported.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_packet_found) |-> (out_packet_start == '0))
    else $error("packet start nonzero without a reported packet");

endmodule

bind pulse_train_packet_detector ptpd_checker u_ptpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_packet_found (out_packet_found),
  .out_packet_start (out_packet_start),
  .out_level        (out_level)
);

@@ tb/tb_pulse_train_packet_detector.sv @@
// Self-checking testbench for pulse_train_packet_detector.
// Depends on ptpd_pkg and the detector RTL; predicts every result item in a scoreboard class.
`timescale 1ns / 1ps

module tb_pulse_train_packet_detector;
  import ptpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned MAX_REPORTS = 10;

  // The sample index stops at the smaller of the index space and the counter range.
  localparam logic [CNT_W-1:0] INDEX_CAP =
      (MAX_SAMPLES_DEF - 1 > CNT_MAX) ? CNT_MAX : CNT_W'(MAX_SAMPLES_DEF - 1);

  // Predicts the level and packet reports and holds the result items still due.
  class packet_scoreboard;
    cfg_t             cfg;
    level_t           lvl;
    logic [CNT_W-1:0] run_len;
    logic [CNT_W-1:0] wrong_len;
    logic [CNT_W-1:0] pkt_len;
    logic [CNT_W-1:0] start_idx;
    logic [CNT_W-1:0] sample_idx;
    result_t          due_q[$];
    int unsigned      failures;

    function new();
      cfg.high_hold_threshold = HIGH_HOLD_RST;
      cfg.low_exit_threshold  = LOW_EXIT_RST;
      cfg.glitch_length       = GLITCH_LEN_RST;
      cfg.empty_length        = EMPTY_LEN_RST;
      cfg.min_packet_length   = MIN_PKT_RST;
      failures = 0;
      clear_detector();
    endfunction

    function void clear_detector();
      lvl        = LVL_IDLE;
      run_len    = '0;
      wrong_len  = '0;
      pkt_len    = '0;
      start_idx  = '0;
      sample_idx = '0;
    endfunction

    function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v, input logic [CNT_W-1:0] cap);
      return (v >= cap) ? cap : v + 1'b1;
    endfunction

    // Indexes past the register list are ignored by the block.
    function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
        REG_HIGH_HOLD:  cfg.high_hold_threshold = val[SAMPLE_W-1:0];
        REG_LOW_EXIT:   cfg.low_exit_threshold  = val[SAMPLE_W-1:0];
        REG_GLITCH_LEN: cfg.glitch_length       = val[GLITCH_W-1:0];
        REG_EMPTY_LEN:  cfg.empty_length        = val[CNT_W-1:0];
        REG_MIN_PKT:    cfg.min_packet_length   = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Advances the detector by one accepted sample and queues the result item.
    function void note_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      result_t r;
      r = '0;
      pkt_len = bump(pkt_len, CNT_MAX);
      if (lvl == LVL_HIGH) begin
        if (s > cfg.high_hold_threshold) begin
          wrong_len = '0;
          if (start_idx == '0) begin
            start_idx = (sample_idx >= run_len) ? sample_idx - run_len : '0;
          end
          run_len = bump(run_len, CNT_MAX);
        end else begin
          wrong_len = bump(wrong_len, CNT_MAX);
          if (wrong_len > cfg.glitch_length) begin
            run_len   = wrong_len;
            wrong_len = '0;
            lvl       = LVL_LOW;
          end
        end
      end else if (s <= cfg.low_exit_threshold) begin
        // A long enough quiet run closes the packet.
        if (run_len > cfg.empty_length) begin
          if (pkt_len >= cfg.min_packet_length && start_idx != '0) begin
            r.packet_found = 1'b1;
            r.packet_start = start_idx;
          end
          pkt_len   = '0;
          start_idx = '0;
          lvl       = LVL_IDLE;
        end
        run_len   = bump(run_len, CNT_MAX);
        wrong_len = '0;
      end else begin
        wrong_len = bump(wrong_len, CNT_MAX);
        if (wrong_len > cfg.glitch_length) begin
          run_len   = wrong_len;
          wrong_len = '0;
          lvl       = LVL_HIGH;
        end
      end
      sample_idx = bump(sample_idx, INDEX_CAP);
      r.level = lvl;
      due_q.push_back(r);
      if (last) begin
        clear_detector();
      end
    endfunction

    // Compares one result item with the oldest one due.
    function void check_result(input logic found, input logic [CNT_W-1:0] start,
                               input logic [1:0] level);
      result_t want;
      if (due_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected result item: found=%0b start=%0d level=%0d",
                   found, start, level);
        end
        return;
      end
      want = due_q.pop_front();
      if (found !== want.packet_found || start !== want.packet_start ||
          level !== want.level) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: expected found=%0b start=%0d level=%0d,",
                   want.packet_found, want.packet_start, want.level,
                   " got found=%0b start=%0d level=%0d", found, start, level);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_HIGH_HOLD;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample      = '0;
  logic                 in_last_sample = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_packet_found;
  logic [CNT_W-1:0]     out_packet_start;
  logic [1:0]           out_level;

  bit                   steady = 1'b0;
  int unsigned          items_sent = 0;
  int unsigned          cycles = 0;
  packet_scoreboard     sb = new();

  pulse_train_packet_detector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packet_found (out_packet_found),
    .out_packet_start (out_packet_start),
    .out_level        (out_level)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random unless a steady stretch is running.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 14);
  end

  // Every result item accepted by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_packet_found, out_packet_start, out_level);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one item, holds it until accepted and returns at the next falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every result item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_register(idx, val);
    @(negedge clk);
  endtask

  // Writes all registers, then the unused indexes with random data.
  task automatic configure(input logic [SAMPLE_W-1:0] hold, input logic [SAMPLE_W-1:0] exit_thr,
                           input logic [GLITCH_W-1:0] glitch, input logic [CNT_W-1:0] empty,
                           input logic [CNT_W-1:0] min_len);
    write_reg(REG_HIGH_HOLD, CFG_W'(hold));
    write_reg(REG_LOW_EXIT, CFG_W'(exit_thr));
    write_reg(REG_GLITCH_LEN, CFG_W'(glitch));
    write_reg(REG_EMPTY_LEN, empty);
    write_reg(REG_MIN_PKT, min_len);
    for (int i = int'(REG_MIN_PKT) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // A sample that counts as high in every state, or the top value if none does.
  function automatic logic [SAMPLE_W-1:0] high_value();
    logic [SAMPLE_W-1:0] thr;
    thr = (sb.cfg.high_hold_threshold > sb.cfg.low_exit_threshold) ?
          sb.cfg.high_hold_threshold : sb.cfg.low_exit_threshold;
    if (thr == {SAMPLE_W{1'b1}}) return thr;
    if ($urandom_range(7) == 0) return thr + 1'b1;
    return SAMPLE_W'($urandom_range(65535, int'(thr) + 1));
  endfunction

  // A sample that counts as low in every state, often right at the threshold.
  function automatic logic [SAMPLE_W-1:0] low_value();
    logic [SAMPLE_W-1:0] thr;
    thr = (sb.cfg.high_hold_threshold < sb.cfg.low_exit_threshold) ?
          sb.cfg.high_hold_threshold : sb.cfg.low_exit_threshold;
    if ($urandom_range(7) == 0) return thr;
    return SAMPLE_W'($urandom_range(int'(thr), 0));
  endfunction

  function automatic logic random_last();
    return $urandom_range(149) == 0;
  endfunction

  // One pulse train: a quiet lead-in, a high burst with glitches, and a low tail
  // sized from the empty length.
  task automatic send_train();
    int unsigned g;
    int unsigned e;
    int unsigned n;
    g = (sb.cfg.glitch_length > 6) ? 6 : sb.cfg.glitch_length;
    e = (sb.cfg.empty_length > 30) ? 30 : sb.cfg.empty_length;
    n = $urandom_range(e + 3, 0);
    repeat (n) send_sample(low_value(), random_last());
    n = $urandom_range(g + 60, g + 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(g + 1, 1)) send_sample(low_value(), random_last());
      end else begin
        send_sample(high_value(), random_last());
      end
    end
    repeat ($urandom_range(e + 6, e + 1)) send_sample(low_value(), random_last());
  endtask

  // Mostly well-formed trains, some raw noise, and now and then a full pause.
  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(20, 5)) send_sample(SAMPLE_W'($urandom), random_last());
      end else begin
        send_train();
      end
      if ($urandom_range(29) == 0) begin
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: threshold edges, a glitch-length high run, end of buffer.
    send_sample(16'd0, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd2001, 1'b0);
    repeat (8) send_sample(16'hFFFF, 1'b0);
    send_sample(16'd1001, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd0, 1'b1);
    drain_results();

    // No glitch filter and no length limits: a short packet is reported, then a
    // packet starting at index zero stays unreported.
    configure(HIGH_HOLD_RST, LOW_EXIT_RST, '0, '0, '0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd2001, 1'b0);
    send_sample(16'd0, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    drain_results();

    // Random traffic under several settings.
    configure(16'd1000, 16'd2000, 10'd3, 20'd12, 20'd25);
    random_phase(300);
    drain_results();
    configure(16'd3000, 16'd500, '0, '0, '0);
    random_phase(200);
    drain_results();
    configure('0, 16'hFFFF, 10'd1, 20'd5, 20'd10);
    random_phase(100);
    drain_results();
    configure(16'hFFFF, '0, 10'd2, 20'd8, 20'd1);
    steady = 1'b1;
    random_phase(200);
    steady = 1'b0;
    drain_results();
    configure(SAMPLE_W'($urandom), SAMPLE_W'($urandom), GLITCH_W'($urandom_range(6, 0)),
              CNT_W'($urandom_range(30, 0)), CNT_W'($urandom_range(60, 0)));
    random_phase(300);
    drain_results();
    configure(HIGH_HOLD_RST, LOW_EXIT_RST, GLITCH_LEN_RST, EMPTY_LEN_RST, MIN_PKT_RST);
    random_phase(150);
    drain_results();

    // Limits at the top of their ranges at full rate: the level never changes
    // and no packet closes.
    configure(HIGH_HOLD_RST, LOW_EXIT_RST, {GLITCH_W{1'b1}}, CNT_MAX, CNT_MAX);
    steady = 1'b1;
    send_sample(16'd0, 1'b1);
    repeat (40) send_sample(16'd0, 1'b0);
    repeat (40) send_sample(16'hFFFF, 1'b0);
    repeat (40) send_sample(16'd0, 1'b0);
    drain_results();
    configure(HIGH_HOLD_RST, LOW_EXIT_RST, '0, '0, CNT_MAX);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);
    steady = 1'b0;
    drain_results();

    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ptpd_pkg.sv
design/ptpd_cfg.sv
design/ptpd_core.sv
design/ptpd_out.sv
design/pulse_train_packet_detector.sv
design/ptpd_checker.sv
tb/tb_pulse_train_packet_detector.sv
